// File: design/convex_polygon_rect_clip_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the polygon clip unit
// Each macro expects signals named clk and rst_n in the module that uses it.
// ----------------------------------------------------------------------------
`ifndef CONVEX_POLYGON_RECT_CLIP_UNIT_MACROS_SVH
`define CONVEX_POLYGON_RECT_CLIP_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
`define CPRC_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");
`define CPRC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`else
`define CPRC_ASSERT(lbl, cond)
`define CPRC_ASSERT_IMPL(lbl, ante, cons)
`endif

`endif

// File: design/cprc_pkg.sv
// ----------------------------------------------------------------------------
// cprc_pkg
// Shared types, constants and helpers of the polygon clip unit.
// ----------------------------------------------------------------------------
package cprc_pkg;

  localparam int MAX_VERT = 8;
  localparam int FQ_DEPTH = 4;
  localparam int CFG_AW   = 4;
  localparam int NUM_W    = 35;
  localparam int DEN_W    = 17;

  typedef logic signed [15:0] coord_t;
  typedef logic signed [16:0] diff_t;

  typedef struct packed {
    coord_t vertex_x;
    coord_t vertex_y;
    logic   last_in;
  } in_item_t;

  typedef struct packed {
    coord_t out_x;
    coord_t out_y;
    logic   last_out;
    logic   empty_res;
    logic   overflow;
  } out_item_t;

  typedef struct packed {
    coord_t left;
    coord_t top;
    coord_t right;
    coord_t bottom;
  } rect_t;

  typedef enum logic [1:0] {
    REG_LEFT   = 2'd0,
    REG_TOP    = 2'd1,
    REG_RIGHT  = 2'd2,
    REG_BOTTOM = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    PASS_TOP    = 2'd0,
    PASS_RIGHT  = 2'd1,
    PASS_BOTTOM = 2'd2,
    PASS_LEFT   = 2'd3
  } pass_t;

  typedef struct packed {
    logic                    start;
    logic signed [NUM_W-1:0] num;
    logic signed [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic   busy;
    logic   done;
    coord_t quo;
  } div_rsp_t;

  // One clip line: horizontal lines test y, vertical lines test x. The side
  // product is g * (coord - c), and a vertex is inside when it is negative.
  typedef struct packed {
    logic   horiz;
    coord_t c;
    diff_t  g;
  } clip_line_t;

  function automatic diff_t sub17(coord_t a, coord_t b);
    diff_t r;
    r = {a[15], a} - {b[15], b};
    return r;
  endfunction

  function automatic clip_line_t line_of(pass_t p, rect_t r);
    clip_line_t l;
    case (p)
      PASS_TOP: begin
        l.horiz = 1'b1;
        l.c     = r.top;
        l.g     = sub17(r.right, r.left);
      end
      PASS_RIGHT: begin
        l.horiz = 1'b0;
        l.c     = r.right;
        l.g     = sub17(r.top, r.bottom);
      end
      PASS_BOTTOM: begin
        l.horiz = 1'b1;
        l.c     = r.bottom;
        l.g     = sub17(r.left, r.right);
      end
      default: begin
        l.horiz = 1'b0;
        l.c     = r.left;
        l.g     = sub17(r.bottom, r.top);
      end
    endcase
    return l;
  endfunction

  function automatic logic is_inside(clip_line_t l, coord_t a);
    logic r;
    r = (l.g != '0) && (a != l.c) && (l.g[16] != (a < l.c));
    return r;
  endfunction

endpackage

// File: design/cprc_div.sv
// ----------------------------------------------------------------------------
// cprc_div
// Restoring divider, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module cprc_div (
  input  logic               clk,
  input  logic               rst_n,
  input  cprc_pkg::div_req_t req,
  output cprc_pkg::div_rsp_t rsp
);
  import cprc_pkg::*;

  localparam int CNT_W = $clog2(NUM_W);

  logic             busy_r, done_r, neg_r;
  logic [CNT_W-1:0] cnt_r;
  logic [NUM_W-1:0] dvd_r;
  logic [DEN_W-1:0] dvs_r, rem_r;
  logic [15:0]      quo_r;

  logic [NUM_W-1:0] num_mag;
  logic [DEN_W-1:0] den_mag;
  logic [DEN_W:0]   rem_sh, rem_sub;
  logic             take;

  always_comb begin
    num_mag = req.num[NUM_W-1] ? (~req.num + 1'b1) : req.num;
    den_mag = req.den[DEN_W-1] ? (~req.den + 1'b1) : req.den;
    rem_sh  = {rem_r, dvd_r[NUM_W-1]};
    rem_sub = rem_sh - {1'b0, dvs_r};
    take    = rem_sh >= {1'b0, dvs_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == CNT_W'(NUM_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd_r <= num_mag;
      dvs_r <= den_mag;
      neg_r <= req.num[NUM_W-1] ^ req.den[DEN_W-1];
      rem_r <= '0;
      cnt_r <= '0;
      quo_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[NUM_W-2:0], 1'b0};
      rem_r <= take ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      quo_r <= {quo_r[14:0], take};
      cnt_r <= cnt_r + 1'b1;
    end
  end

  // Only the low 16 bits of the quotient are kept; negation commutes with that.
  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quo  = neg_r ? coord_t'(~quo_r + 1'b1) : coord_t'(quo_r);

endmodule

// File: design/cprc_front.sv
// ----------------------------------------------------------------------------
// cprc_front
// Input side: takes vertex items and queues them for the clip engine.
// ----------------------------------------------------------------------------
module cprc_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  cprc_pkg::in_item_t in_data,
  output logic               q_valid,
  output cprc_pkg::in_item_t q_item,
  input  logic               q_pop
);
  import cprc_pkg::*;

  localparam int PW = $clog2(FQ_DEPTH);
  localparam int CW = $clog2(FQ_DEPTH + 1);

  in_item_t        fifo_r [FQ_DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   cnt_r;
  logic            do_wr, do_rd;

  assign full    = (cnt_r == CW'(FQ_DEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_item  = fifo_r[rd_ptr_r];
  assign do_wr   = push && !full;
  assign do_rd   = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_wr) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_rd) rd_ptr_r <= rd_ptr_r + 1'b1;
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) fifo_r[wr_ptr_r] <= in_data;
  end

endmodule

// File: design/cprc_engine.sv
// ----------------------------------------------------------------------------
// cprc_engine
// Back end: stores vertices, runs the four clip passes, delivers results.
// ----------------------------------------------------------------------------
`include "convex_polygon_rect_clip_unit_macros.svh"

module cprc_engine #(
  parameter int MaxV = cprc_pkg::MAX_VERT
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  cprc_pkg::in_item_t  q_item,
  output logic                q_pop,
  input  cprc_pkg::rect_t     rect,
  output logic                empty,
  input  logic                pop,
  output cprc_pkg::out_item_t out_data
);
  import cprc_pkg::*;

  localparam int IW    = $clog2(MaxV);
  localparam int CW    = $clog2(MaxV + 1);
  localparam int DEPTH = 2 * (1 << IW);

  typedef enum logic [11:0] {
    S_LOAD   = 12'b000000000001,
    S_PSTART = 12'b000000000010,
    S_FIRST  = 12'b000000000100,
    S_FETCH  = 12'b000000001000,
    S_EDGE   = 12'b000000010000,
    S_MUL1   = 12'b000000100000,
    S_MUL2   = 12'b000001000000,
    S_DIV    = 12'b000010000000,
    S_PUSHK  = 12'b000100000000,
    S_NEXT   = 12'b001000000000,
    S_PEND   = 12'b010000000000,
    S_OUT    = 12'b100000000000
  } state_t;

  state_t          state_r;
  logic            owr_r;
  logic            bank_r, ovf_r, final_r, pendk_r, out_full_r;
  logic [CW-1:0]   scnt_r, dcnt_r, idx_r;
  pass_t           pass_r;
  logic [31:0]     first_r, prev_r, rdata_r;
  logic signed [32:0] prod_r;
  out_item_t       out_r;

  logic [31:0]     mem [DEPTH];
  logic            wr_en, rd_en;
  logic [IW:0]     wr_addr, rd_addr;
  logic [31:0]     wr_data;

  div_req_t        dreq;
  div_rsp_t        drsp;

  clip_line_t      ln;
  logic [31:0]     cur;
  coord_t          iu, iv, ku, kv;
  diff_t           dv, du, dc;
  logic            in_i, in_k, dest_ok, out_last;

  cprc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .rsp   (drsp)
  );

  always_comb begin
    ln  = line_of(pass_r, rect);
    cur = final_r ? first_r : rdata_r;
    if (ln.horiz) begin
      iu = prev_r[31:16];
      iv = prev_r[15:0];
      ku = cur[31:16];
      kv = cur[15:0];
    end else begin
      iu = prev_r[15:0];
      iv = prev_r[31:16];
      ku = cur[15:0];
      kv = cur[31:16];
    end
    dv       = sub17(kv, iv);
    du       = sub17(ku, iu);
    dc       = sub17(ln.c, iv);
    in_i     = is_inside(ln, iv);
    in_k     = is_inside(ln, kv);
    dest_ok  = dcnt_r < CW'(MaxV);
    out_last = (CW'(idx_r + 1'b1) == scnt_r);
    dreq.start = (state_r == S_MUL2);
    dreq.num   = 35'(prod_r) + 35'(dc) * 35'(du);
    dreq.den   = dv;
  end

  // Memory port control. The two banks of the store alternate as source and
  // destination from one pass to the next.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = {~bank_r, dcnt_r[IW-1:0]};
    wr_data = cur;
    rd_en   = 1'b0;
    rd_addr = {bank_r, idx_r[IW-1:0]};
    q_pop   = 1'b0;
    case (state_r)
      S_LOAD: begin
        q_pop   = q_valid;
        wr_en   = q_valid && (scnt_r < CW'(MaxV));
        wr_addr = {bank_r, scnt_r[IW-1:0]};
        wr_data = {q_item.vertex_x, q_item.vertex_y};
      end
      S_PSTART: begin
        rd_en   = (scnt_r != '0);
        rd_addr = {bank_r, {IW{1'b0}}};
      end
      S_FETCH: rd_en = (idx_r < scnt_r);
      S_EDGE:  wr_en = in_i && in_k && dest_ok;
      S_DIV: begin
        wr_en   = drsp.done && dest_ok;
        wr_data = ln.horiz ? {drsp.quo, ln.c} : {ln.c, drsp.quo};
      end
      S_PUSHK: wr_en = dest_ok;
      S_OUT:   rd_en = !owr_r && !out_full_r && (scnt_r != '0);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_LOAD;
      owr_r      <= 1'b0;
      bank_r     <= 1'b0;
      ovf_r      <= 1'b0;
      final_r    <= 1'b0;
      pendk_r    <= 1'b0;
      out_full_r <= 1'b0;
      scnt_r     <= '0;
      dcnt_r     <= '0;
      idx_r      <= '0;
      pass_r     <= PASS_TOP;
    end else begin
      if (pop && out_full_r) out_full_r <= 1'b0;
      case (state_r)
        S_LOAD: begin
          if (q_valid) begin
            if (scnt_r < CW'(MaxV)) begin
              scnt_r <= scnt_r + 1'b1;
            end else begin
              ovf_r <= 1'b1;
            end
            if (q_item.last_in) begin
              pass_r  <= PASS_TOP;
              state_r <= S_PSTART;
            end
          end
        end
        S_PSTART: begin
          dcnt_r  <= '0;
          state_r <= (scnt_r == '0) ? S_PEND : S_FIRST;
        end
        S_FIRST: begin
          first_r <= rdata_r;
          prev_r  <= rdata_r;
          final_r <= 1'b0;
          idx_r   <= CW'(1);
          state_r <= S_FETCH;
        end
        S_FETCH: begin
          // Past the last stored vertex the closing edge goes back to the first.
          final_r <= !(idx_r < scnt_r);
          state_r <= S_EDGE;
        end
        S_EDGE: begin
          pendk_r <= !in_i;
          if (in_i && in_k) begin
            if (dest_ok) begin
              dcnt_r <= dcnt_r + 1'b1;
            end else begin
              ovf_r <= 1'b1;
            end
            state_r <= S_NEXT;
          end else if (in_i != in_k) begin
            state_r <= S_MUL1;
          end else begin
            state_r <= S_NEXT;
          end
        end
        S_MUL1: begin
          prod_r  <= 33'(iu) * 33'(dv);
          state_r <= S_MUL2;
        end
        S_MUL2: state_r <= S_DIV;
        S_DIV: begin
          if (drsp.done) begin
            if (dest_ok) begin
              dcnt_r <= dcnt_r + 1'b1;
            end else begin
              ovf_r <= 1'b1;
            end
            state_r <= pendk_r ? S_PUSHK : S_NEXT;
          end
        end
        S_PUSHK: begin
          if (dest_ok) begin
            dcnt_r <= dcnt_r + 1'b1;
          end else begin
            ovf_r <= 1'b1;
          end
          state_r <= S_NEXT;
        end
        S_NEXT: begin
          prev_r <= cur;
          if (final_r) begin
            state_r <= S_PEND;
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_FETCH;
          end
        end
        S_PEND: begin
          scnt_r <= dcnt_r;
          bank_r <= ~bank_r;
          idx_r  <= '0;
          if (pass_r == PASS_LEFT) begin
            state_r <= S_OUT;
          end else begin
            pass_r  <= pass_t'(pass_r + 1'b1);
            state_r <= S_PSTART;
          end
        end
        S_OUT: begin
          if (owr_r) begin
            owr_r      <= 1'b0;
            out_full_r <= 1'b1;
            out_r      <= '{out_x: rdata_r[31:16], out_y: rdata_r[15:0],
                            last_out: out_last, empty_res: 1'b0, overflow: ovf_r};
            if (out_last) begin
              scnt_r  <= '0;
              ovf_r   <= 1'b0;
              idx_r   <= '0;
              state_r <= S_LOAD;
            end else begin
              idx_r <= idx_r + 1'b1;
            end
          end else if (!out_full_r) begin
            if (scnt_r == '0) begin
              out_full_r <= 1'b1;
              out_r      <= '{out_x: '0, out_y: '0, last_out: 1'b1,
                              empty_res: 1'b1, overflow: ovf_r};
              ovf_r      <= 1'b0;
              state_r    <= S_LOAD;
            end else begin
              owr_r <= 1'b1;
            end
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

  assign empty    = !out_full_r;
  assign out_data = out_r;

  `CPRC_ASSERT(a_dcnt_cap, dcnt_r <= CW'(MaxV))
  `CPRC_ASSERT(a_scnt_cap, scnt_r <= CW'(MaxV))
  `CPRC_ASSERT_IMPL(a_div_idle, dreq.start, !drsp.busy)
  `CPRC_ASSERT_IMPL(a_out_slot, owr_r, !out_full_r)

endmodule

// File: design/convex_polygon_rect_clip_unit.sv
// ----------------------------------------------------------------------------
// convex_polygon_rect_clip_unit
// Clips a convex polygon against a rectangle, one edge of it per pass.
// ----------------------------------------------------------------------------
// Usage: write clip_left, clip_top, clip_right and clip_bottom over the APB
// port (byte addresses 0, 4, 8, 12) while the unit is idle. Push the polygon
// vertices in order on the input queue; the item with last_in set starts the
// clip. Up to MAX_VERTICES vertices are kept, later ones are dropped and flag
// overflow on every result of that polygon.
// Loading takes one vertex per cycle while the queue holds vertices and the
// engine is not clipping; a four-entry input queue decouples the producer
// from the clip engine. An edge that crosses the clip line waits for the
// bit-serial divider (35 quotient bits), and its far end is kept too when it
// lies inside. Results then leave one at a time, each after the last is
// popped; a polygon clipped away gives a single item with empty_res set.
// Results sit in one output register; while the receiver does not pop, the
// engine waits, and vertices of the next polygon fill the input queue.
// Reset clears the clip rectangle to zero, the counts and the flags.
// ----------------------------------------------------------------------------
module convex_polygon_rect_clip_unit #(
  parameter int MAX_VERTICES = cprc_pkg::MAX_VERT
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  output logic                        full,
  input  cprc_pkg::in_item_t          in_data,
  output logic                        empty,
  input  logic                        pop,
  output cprc_pkg::out_item_t         out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cprc_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import cprc_pkg::*;

  rect_t    rect_r;
  reg_idx_t reg_sel;
  logic     q_valid, q_pop;
  in_item_t q_item;

  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rect_r <= '0;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_sel)
        REG_LEFT:   rect_r.left   <= pwdata[15:0];
        REG_TOP:    rect_r.top    <= pwdata[15:0];
        REG_RIGHT:  rect_r.right  <= pwdata[15:0];
        REG_BOTTOM: rect_r.bottom <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_LEFT:   prdata = {16'h0, rect_r.left};
      REG_TOP:    prdata = {16'h0, rect_r.top};
      REG_RIGHT:  prdata = {16'h0, rect_r.right};
      REG_BOTTOM: prdata = {16'h0, rect_r.bottom};
      default:    prdata = '0;
    endcase
  end

  cprc_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_data (in_data),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  cprc_engine #(
    .MaxV (MAX_VERTICES)
  ) u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .rect     (rect_r),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

endmodule

// File: bench/tb_convex_polygon_rect_clip_unit.sv
// ----------------------------------------------------------------------------
// Polygon clip unit testbench
// Loads polygons through the input queue and clips them against a series of
// rectangles written over APB. Every result popped from the unit is compared
// with a local model of the four-sided clip. The run starts with two directed
// tables and then random polygons under changing idle and stall patterns.
// ----------------------------------------------------------------------------
module tb_convex_polygon_rect_clip_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import cprc_pkg::*;

  localparam int MAXV       = MAX_VERT;
  localparam int CYCLE_CAP  = 1000000;
  localparam int PHASE_ITEMS = 145;

  typedef struct {
    in_item_t  it;
    bit        typed;
    out_item_t res;
  } vec_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  logic full;
  in_item_t in_data = '0;
  logic empty;
  logic pop = 1'b0;
  out_item_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  // Model state.
  coord_t rect_l, rect_t_, rect_r, rect_b;
  coord_t poly_x[MAXV], poly_y[MAXV];
  coord_t next_x[MAXV], next_y[MAXV];
  int     poly_n, next_n;
  bit     drop_seen;

  out_item_t clipped_q[$];
  int  mismatches = 0;
  int  send_idle = 0, recv_idle = 0;
  int  hold_cycles = 0;
  int  cycles = 0;

  convex_polygon_rect_clip_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .push(push), .full(full), .in_data(in_data),
    .empty(empty), .pop(pop), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic void keep_vertex(coord_t x, coord_t y);
    if (next_n < MAXV) begin
      next_x[next_n] = x;
      next_y[next_n] = y;
      next_n++;
    end else begin
      drop_seen = 1'b1;
    end
  endfunction

  // Determinant intersection of clip line A with polygon edge B.
  function automatic bit edge_cross(longint ax0, longint ay0, longint ax1, longint ay1,
                                    longint bx0, longint by0, longint bx1, longint by1,
                                    output coord_t ox, output coord_t oy);
    longint den, ca, cb, xn, yn, qx, qy;
    den = (ax0 - ax1) * (by0 - by1) - (ay0 - ay1) * (bx0 - bx1);
    ox = '0;
    oy = '0;
    if (den == 0) return 1'b0;
    ca = ax0 * ay1 - ay0 * ax1;
    cb = bx0 * by1 - by0 * bx1;
    xn = ca * (bx0 - bx1) - (ax0 - ax1) * cb;
    yn = ca * (by0 - by1) - (ay0 - ay1) * cb;
    qx = xn / den;
    qy = yn / den;
    ox = qx[15:0];
    oy = qy[15:0];
    return 1'b1;
  endfunction

  function automatic void clip_edge(longint x1, longint y1, longint x2, longint y2);
    longint ix, iy, kx, ky, ip, kp;
    coord_t px, py;
    int k;
    next_n = 0;
    for (int i = 0; i < poly_n; i++) begin
      k = (i + 1 == poly_n) ? 0 : i + 1;
      ix = poly_x[i];
      iy = poly_y[i];
      kx = poly_x[k];
      ky = poly_y[k];
      ip = (x2 - x1) * (iy - y1) - (y2 - y1) * (ix - x1);
      kp = (x2 - x1) * (ky - y1) - (y2 - y1) * (kx - x1);
      if (ip < 0 && kp < 0) begin
        keep_vertex(poly_x[k], poly_y[k]);
      end else if (ip >= 0 && kp < 0) begin
        if (edge_cross(x1, y1, x2, y2, ix, iy, kx, ky, px, py)) begin
          keep_vertex(px, py);
          keep_vertex(poly_x[k], poly_y[k]);
        end
      end else if (ip < 0 && kp >= 0) begin
        if (edge_cross(x1, y1, x2, y2, ix, iy, kx, ky, px, py)) keep_vertex(px, py);
      end
    end
    for (int i = 0; i < next_n; i++) begin
      poly_x[i] = next_x[i];
      poly_y[i] = next_y[i];
    end
    poly_n = next_n;
  endfunction

  function automatic void load_vertex(in_item_t it);
    out_item_t r;
    if (poly_n < MAXV) begin
      poly_x[poly_n] = it.vertex_x;
      poly_y[poly_n] = it.vertex_y;
      poly_n++;
    end else begin
      drop_seen = 1'b1;
    end
    if (!it.last_in) return;
    clip_edge(rect_l, rect_t_, rect_r, rect_t_);
    clip_edge(rect_r, rect_t_, rect_r, rect_b);
    clip_edge(rect_r, rect_b, rect_l, rect_b);
    clip_edge(rect_l, rect_b, rect_l, rect_t_);
    if (poly_n == 0) begin
      r = '{out_x: '0, out_y: '0, last_out: 1'b1, empty_res: 1'b1, overflow: drop_seen};
      clipped_q.push_back(r);
    end else begin
      for (int i = 0; i < poly_n; i++) begin
        r = '{out_x: poly_x[i], out_y: poly_y[i], last_out: (i + 1 == poly_n),
              empty_res: 1'b0, overflow: drop_seen};
        clipped_q.push_back(r);
      end
    end
    poly_n = 0;
    drop_seen = 1'b0;
  endfunction

  // Result side: check what was popped at this edge, then pick the next pop.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (clipped_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result item %p", out_data);
        end else begin
          want = clipped_q.pop_front();
          if (out_data.out_x !== want.out_x || out_data.out_y !== want.out_y ||
              out_data.last_out !== want.last_out ||
              out_data.empty_res !== want.empty_res ||
              out_data.overflow !== want.overflow) begin
            mismatches++;
            if (mismatches <= 10) $display("result mismatch: expected %p, got %p", want, out_data);
          end
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  task automatic send_vertex(in_item_t it, bit typed = 1'b0, out_item_t res = '0);
    int mark;
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (full);
    mark = clipped_q.size();
    load_vertex(it);
    if (typed) begin
      while (clipped_q.size() > mark) void'(clipped_q.pop_back());
      clipped_q.push_back(res);
    end
  endtask

  task automatic drain();
    push <= 1'b0;
    while (clipped_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, coord_t v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CFG_AW'(int'(idx) * 4);
    pwdata <= {{16{v[15]}}, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_LEFT:   rect_l = v;
      REG_TOP:    rect_t_ = v;
      REG_RIGHT:  rect_r = v;
      default:    rect_b = v;
    endcase
  endtask

  task automatic set_rect(coord_t l, coord_t t, coord_t r, coord_t b);
    write_reg(REG_LEFT, l);
    write_reg(REG_TOP, t);
    write_reg(REG_RIGHT, r);
    write_reg(REG_BOTTOM, b);
  endtask

  task automatic random_rect();
    int sel, cx, cy, w, h;
    sel = $urandom_range(9);
    cx = $urandom_range(4000) - 2000;
    cy = $urandom_range(4000) - 2000;
    w = $urandom_range(2000, 1);
    h = $urandom_range(2000, 1);
    case (sel)
      0: set_rect(16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000);
      1: set_rect('0, '0, '0, '0);
      2: set_rect(coord_t'(cx + w), coord_t'(cy - h), coord_t'(cx - w), coord_t'(cy + h));
      3: set_rect(coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                  coord_t'($urandom));
      default: set_rect(coord_t'(cx - w), coord_t'(cy + h), coord_t'(cx + w), coord_t'(cy - h));
    endcase
  endtask

  // Mostly a convex polygon on eight compass directions around a point near the rectangle; some get random vertices.
  task automatic random_polygon(inout int sent);
    int dx[8] = '{10, 7, 0, -7, -10, -7, 0, 7};
    int dy[8] = '{0, 7, 10, 7, 0, -7, -10, -7};
    int n, cx, cy, rad, start, dir, j;
    in_item_t it;
    if ($urandom_range(99) < 15) begin
      n = $urandom_range(12, 1);
      for (int i = 0; i < n; i++) begin
        it = '{vertex_x: coord_t'($urandom), vertex_y: coord_t'($urandom), last_in: (i == n - 1)};
        send_vertex(it);
        sent++;
      end
      return;
    end
    n = ($urandom_range(9) == 0) ? $urandom_range(12, 9) : $urandom_range(8, 3);
    cx = (int'(rect_l) + int'(rect_r)) / 2 + int'($urandom_range(1200)) - 600;
    cy = (int'(rect_t_) + int'(rect_b)) / 2 + int'($urandom_range(1200)) - 600;
    rad = ($urandom_range(19) == 0) ? $urandom_range(4000) : $urandom_range(200, 1);
    start = $urandom_range(7);
    dir = $urandom_range(1) ? 1 : 7;
    for (int i = 0; i < n; i++) begin
      j = (start + i * dir) % 8;
      it = '{vertex_x: coord_t'(cx + dx[j] * (rad + i) / 10),
             vertex_y: coord_t'(cy + dy[j] * (rad + i) / 10),
             last_in: (i == n - 1)};
      send_vertex(it);
      sent++;
    end
  endtask

  initial begin
    vec_row_t zero_rect_rows[12];
    vec_row_t box_rows[14];
    out_item_t void_res, void_ovf;
    int sent;
    void_res = '{out_x: '0, out_y: '0, last_out: 1'b1, empty_res: 1'b1, overflow: 1'b0};
    void_ovf = '{out_x: '0, out_y: '0, last_out: 1'b1, empty_res: 1'b1, overflow: 1'b1};
    rect_l = '0; rect_t_ = '0; rect_r = '0; rect_b = '0;
    poly_n = 0;
    drop_seen = 1'b0;

    // With the reset rectangle nothing is ever inside, so every polygon clips away.
    zero_rect_rows[0] = '{'{16'sh0000, 16'sh0000, 1'b0}, 1'b0, '0};
    zero_rect_rows[1] = '{'{16'sh7fff, 16'sh8000, 1'b0}, 1'b0, '0};
    zero_rect_rows[2] = '{'{16'sh8000, 16'sh7fff, 1'b1}, 1'b1, void_res};
    for (int i = 0; i < 9; i++)
      zero_rect_rows[3 + i] = '{'{coord_t'(i * 3000 - 12000), coord_t'(5 - i), i == 8},
                                i == 8, void_ovf};

    box_rows[0]  = '{'{16'sd10, 16'sd10, 1'b0}, 1'b0, '0};
    box_rows[1]  = '{'{16'sd50, -16'sd20, 1'b0}, 1'b0, '0};
    box_rows[2]  = '{'{-16'sd30, 16'sd40, 1'b1}, 1'b0, '0};
    box_rows[3]  = '{'{-16'sd200, -16'sd200, 1'b0}, 1'b0, '0};
    box_rows[4]  = '{'{16'sd200, -16'sd200, 1'b0}, 1'b0, '0};
    box_rows[5]  = '{'{16'sd0, 16'sd300, 1'b1}, 1'b0, '0};
    // Octagon larger than the box: clipping adds corners past capacity.
    box_rows[6]  = '{'{16'sd140, 16'sd0, 1'b0}, 1'b0, '0};
    box_rows[7]  = '{'{16'sd99, 16'sd99, 1'b0}, 1'b0, '0};
    box_rows[8]  = '{'{16'sd0, 16'sd140, 1'b0}, 1'b0, '0};
    box_rows[9]  = '{'{-16'sd99, 16'sd99, 1'b0}, 1'b0, '0};
    box_rows[10] = '{'{-16'sd140, 16'sd0, 1'b0}, 1'b0, '0};
    box_rows[11] = '{'{-16'sd99, -16'sd99, 1'b0}, 1'b0, '0};
    box_rows[12] = '{'{16'sd0, -16'sd140, 1'b0}, 1'b0, '0};
    box_rows[13] = '{'{16'sd99, -16'sd99, 1'b1}, 1'b0, '0};

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (zero_rect_rows[i])
      send_vertex(zero_rect_rows[i].it, zero_rect_rows[i].typed, zero_rect_rows[i].res);
    drain();
    set_rect(-16'sd100, 16'sd100, 16'sd100, -16'sd100);
    foreach (box_rows[i]) send_vertex(box_rows[i].it);
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle = (phase == 0) ? 35 : (phase == 1) ? 65 : 0;
      recv_idle = (phase == 0) ? 65 : (phase == 1) ? 35 : 0;
      // Long receiver stall so the input queue fills and push is refused.
      if (phase == 2) hold_cycles = 3000;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        random_rect();
        for (int p = 0; p < 8 && sent < PHASE_ITEMS; p++) random_polygon(sent);
        drain();
      end
    end

    repeat (100) @(posedge clk);
    if (mismatches == 0 && clipped_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+design
design/cprc_pkg.sv
design/cprc_div.sv
design/cprc_front.sv
design/cprc_engine.sv
design/convex_polygon_rect_clip_unit.sv
bench/tb_convex_polygon_rect_clip_unit.sv
